/* src/fpfa_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpfa_pkg: shared types and codes for the fixed-partition fit allocator
// transfer payloads, policy, function and register codes, sequencer states
// ----------------------------------------------------------------------------
package fpfa_pkg;

    // input item: load a partition size or request an allocation
    typedef struct packed {
        logic        func;
        logic [3:0]  partition_index;
        logic [15:0] amount;
    } t_in_item;

    // result item, one for each request
    typedef struct packed {
        logic        granted;
        logic [3:0]  granted_index;
        logic [15:0] granted_size;
        logic [15:0] request_number;
    } t_out_item;

    // grant decision from the fit unit, in output field widths
    typedef struct packed {
        logic        granted;
        logic [3:0]  index;
        logic [15:0] size;
    } t_fit_result;

    // item functions
    localparam logic FUNC_LOAD    = 1'b0;
    localparam logic FUNC_REQUEST = 1'b1;

    // placement policies (code 3 never grants)
    localparam logic [1:0] POL_FIRST = 2'd0;
    localparam logic [1:0] POL_BEST  = 2'd1;
    localparam logic [1:0] POL_WORST = 2'd2;

    // register select, paddr bit 2
    localparam logic REG_POLICY = 1'b0;
    localparam logic REG_COUNT  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_COMMIT
    } t_state;

endpackage : fpfa_pkg
`default_nettype wire

/* src/fpfa_size_mem.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpfa_size_mem: partition size memory
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module fpfa_size_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int DW    = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule : fpfa_size_mem
`default_nettype wire

/* src/fpfa_fit_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpfa_fit_unit: shared compare unit for the partition scan
// takes one partition a cycle and keeps the best candidate so far
// ----------------------------------------------------------------------------
module fpfa_fit_unit #(
    parameter int IDX_W     = 4,
    parameter int SIZE_BITS = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [1:0]           i_policy,
    input  wire logic [15:0]          i_need,
    input  wire logic                 i_smp_vld,
    input  wire logic                 i_smp_free,
    input  wire logic [IDX_W-1:0]     i_smp_idx,
    input  wire logic [SIZE_BITS-1:0] i_smp_size,
    output fpfa_pkg::t_fit_result     o_result,
    output logic      [IDX_W-1:0]     o_pick_idx
);
    import fpfa_pkg::*;

    localparam int CW = (SIZE_BITS > 16) ? SIZE_BITS : 16;

    logic                 r_found;
    logic [IDX_W-1:0]     r_pick_idx;
    logic [SIZE_BITS-1:0] r_pick_size;

    logic                 take;
    logic                 fits;
    logic                 smaller;
    logic                 larger;
    logic                 pick_fits;
    logic [CW-1:0]        size_ext;
    logic [CW-1:0]        pick_ext;
    logic [CW-1:0]        need_ext;
    logic [IDX_W+3:0]     idx_wide;
    logic [SIZE_BITS+15:0] size_wide;

    assign size_ext = CW'(i_smp_size);
    assign pick_ext = CW'(r_pick_size);
    assign need_ext = CW'(i_need);

    assign fits      = size_ext >= need_ext;
    assign smaller   = size_ext < pick_ext;
    assign larger    = size_ext > pick_ext;
    assign pick_fits = pick_ext >= need_ext;

    always_comb begin
        take = 1'b0;
        if (i_smp_vld && i_smp_free) begin
            case (i_policy)
                POL_FIRST: take = fits && !r_found;
                POL_BEST:  take = fits && (!r_found || smaller);
                POL_WORST: take = !r_found || larger;
                default:   take = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_start) begin
            r_found <= 1'b0;
        end else if (take) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_pick_idx  <= i_smp_idx;
            r_pick_size <= i_smp_size;
        end
    end

    // worst fit checks the largest candidate against the request at the end
    assign idx_wide  = (IDX_W + 4)'(r_pick_idx);
    assign size_wide = (SIZE_BITS + 16)'(r_pick_size);

    always_comb begin
        o_result.granted = r_found && ((i_policy != POL_WORST) || pick_fits);
        o_result.index   = o_result.granted ? idx_wide[3:0] : 4'd0;
        o_result.size    = o_result.granted ? size_wide[15:0] : 16'd0;
    end

    assign o_pick_idx = r_pick_idx;

endmodule : fpfa_fit_unit
`default_nettype wire

/* src/fixed_partition_fit_allocator_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fixed_partition_fit_allocator_unit: fixed-partition fit allocator
// keeps partition sizes and free flags, grants requests by first, best or
// worst fit under the policy register
// ----------------------------------------------------------------------------
//
//  channel   | direction | handshake            | payload
//  ----------+-----------+----------------------+---------------------------
//  input     | in        | i_valid / o_stall    | i_data  (t_in_item)
//  result    | out       | o_valid / i_stall    | o_data  (t_out_item)
//  config    | in        | psel/penable/pready  | paddr, pwdata, prdata
//
//  a load transfer is taken in idle; the next item can follow right away
//  a request runs through accept, a scan of each partition up to limit
//  through the single read port of the size memory, drain and commit;
//  limit is min(partition_count, NUM_PARTITIONS)
//  commit waits while a previous result is still stalled on the output
//  reset clears the free flags, counter, registers and control at once; no
//  clearing pass is run
//
module fixed_partition_fit_allocator_unit #(
    parameter int NUM_PARTITIONS = 16,
    parameter int SIZE_BITS      = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // input channel
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire fpfa_pkg::t_in_item  i_data,
    // result channel
    output logic                     o_valid,
    input  wire logic                i_stall,
    output fpfa_pkg::t_out_item      o_data,
    // register port
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [2:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic      [31:0]         prdata,
    output logic                     pready
);
    import fpfa_pkg::*;

    localparam int IDX_W = (NUM_PARTITIONS > 1) ? $clog2(NUM_PARTITIONS) : 1;
    localparam int CNT_W = $clog2(NUM_PARTITIONS + 1);

    // registers
    t_state               r_state;
    t_state               n_state;
    logic [1:0]           r_cfg_policy;
    logic [4:0]           r_cfg_count;
    logic [1:0]           r_policy;
    logic [15:0]          r_need;
    logic [CNT_W-1:0]     r_scan;
    logic [CNT_W-1:0]     r_lim;
    logic [15:0]          r_req_cnt;
    logic [NUM_PARTITIONS-1:0] r_free;
    logic                 r_rd_vld;
    logic                 r_rd_free;
    logic [IDX_W-1:0]     r_rd_idx;
    logic                 r_out_vld;
    t_out_item            r_out_data;

    // control
    logic                 in_xfer;
    logic                 load_xfer;
    logic                 req_xfer;
    logic                 load_hit;
    logic                 issue;
    logic                 last_issue;
    logic                 out_free;
    logic                 commit;
    logic                 cfg_wr;
    logic [CNT_W-1:0]     lim_calc;
    logic [IDX_W-1:0]     scan_addr;
    logic [IDX_W+3:0]     load_idx_wide;
    logic [IDX_W-1:0]     load_addr;
    logic [SIZE_BITS+15:0] load_size_wide;
    logic [SIZE_BITS-1:0] load_size;
    logic [SIZE_BITS-1:0] rd_size;
    t_fit_result          fit_res;
    logic [IDX_W-1:0]     pick_idx;

    // ---------------- register port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_policy <= POL_FIRST;
            r_cfg_count  <= 5'd0;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_POLICY: r_cfg_policy <= pwdata[1:0];
                REG_COUNT:  r_cfg_count  <= pwdata[4:0];
                default:    r_cfg_policy <= r_cfg_policy;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_POLICY: prdata = {30'd0, r_cfg_policy};
            REG_COUNT:  prdata = {27'd0, r_cfg_count};
            default:    prdata = 32'd0;
        endcase
    end

    // ---------------- input decode ----------------
    // scan limit, the count clamped to the table depth
    assign lim_calc = CNT_W'((32'(r_cfg_count) > NUM_PARTITIONS) ?
                             NUM_PARTITIONS : 32'(r_cfg_count));

    assign in_xfer   = i_valid && !o_stall;
    assign load_xfer = in_xfer && (i_data.func == FUNC_LOAD);
    assign req_xfer  = in_xfer && (i_data.func == FUNC_REQUEST);

    // loads beyond the table are dropped
    assign load_hit       = load_xfer && (32'(i_data.partition_index) < NUM_PARTITIONS);
    assign load_idx_wide  = (IDX_W + 4)'(i_data.partition_index);
    assign load_addr      = load_idx_wide[IDX_W-1:0];
    assign load_size_wide = (SIZE_BITS + 16)'(i_data.amount);
    assign load_size      = load_size_wide[SIZE_BITS-1:0];

    assign scan_addr  = r_scan[IDX_W-1:0];
    assign last_issue = (r_scan + CNT_W'(1)) == r_lim;

    // output register frees when empty or when its result is taken
    assign out_free = !r_out_vld || !i_stall;

    // ---------------- sequencer ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (req_xfer) begin
                    n_state = (lim_calc == '0) ? ST_DRAIN : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (last_issue) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_stall = 1'b1;
        issue   = 1'b0;
        commit  = 1'b0;
        case (r_state)
            ST_IDLE:   o_stall = 1'b0;
            ST_SCAN:   issue   = 1'b1;
            ST_DRAIN:  o_stall = 1'b1;
            ST_COMMIT: commit  = out_free;
            default:   o_stall = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // request context, latched on accept
    always_ff @(posedge i_clk) begin
        if (req_xfer) begin
            r_policy <= r_cfg_policy;
            r_need   <= i_data.amount;
            r_lim    <= lim_calc;
        end
    end

    // scan pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan <= '0;
        end else if (req_xfer) begin
            r_scan <= '0;
        end else if (issue) begin
            r_scan <= r_scan + CNT_W'(1);
        end
    end

    // running request count, value after this request goes into the result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_cnt <= 16'd0;
        end else if (req_xfer) begin
            r_req_cnt <= r_req_cnt + 16'd1;
        end
    end

    // free flags: set by a load, cleared by a granted commit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free <= '0;
        end else if (load_hit) begin
            r_free[load_addr] <= 1'b1;
        end else if (commit && fit_res.granted) begin
            r_free[pick_idx] <= 1'b0;
        end
    end

    // read stage, lines up free flag and index with the memory data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_rd_idx  <= scan_addr;
            r_rd_free <= r_free[scan_addr];
        end
    end

    fpfa_size_mem #(
        .DEPTH (NUM_PARTITIONS),
        .AW    (IDX_W),
        .DW    (SIZE_BITS)
    ) u_size_mem (
        .i_clk   (i_clk),
        .i_we    (load_hit),
        .i_waddr (load_addr),
        .i_wdata (load_size),
        .i_re    (issue),
        .i_raddr (scan_addr),
        .o_rdata (rd_size)
    );

    fpfa_fit_unit #(
        .IDX_W     (IDX_W),
        .SIZE_BITS (SIZE_BITS)
    ) u_fit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (req_xfer),
        .i_policy   (r_policy),
        .i_need     (r_need),
        .i_smp_vld  (r_rd_vld),
        .i_smp_free (r_rd_free),
        .i_smp_idx  (r_rd_idx),
        .i_smp_size (rd_size),
        .o_result   (fit_res),
        .o_pick_idx (pick_idx)
    );

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (commit) begin
            r_out_vld <= 1'b1;
        end else if (!i_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_out_data.granted        <= fit_res.granted;
            r_out_data.granted_index  <= fit_res.index;
            r_out_data.granted_size   <= fit_res.size;
            r_out_data.request_number <= r_req_cnt;
        end
    end

    assign o_valid = r_out_vld;
    assign o_data  = r_out_data;

endmodule : fixed_partition_fit_allocator_unit
`default_nettype wire

/* src/fpfa_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpfa_checker: port-level checks for the fit allocator
// bound to the top level
// ----------------------------------------------------------------------------
module fpfa_checker (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    input  wire logic                o_stall,
    input  wire fpfa_pkg::t_in_item  i_data,
    input  wire logic                o_valid,
    input  wire logic                i_stall,
    input  wire fpfa_pkg::t_out_item o_data
);
    import fpfa_pkg::*;

    // a result waiting on a stall holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("result changed while stalled");

    // a refused request carries zero index and size
    a_no_grant_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.granted |->
            (o_data.granted_index == 4'd0) && (o_data.granted_size == 16'd0))
        else $error("refused request with nonzero index or size");

    // an accepted request leaves idle for the scan or drain state, so the input stalls next cycle
    a_req_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && (i_data.func == FUNC_REQUEST) |=> o_stall)
        else $error("input not stalled after a request transfer");

    // a load alone never produces a result on an idle output
    a_load_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && (i_data.func == FUNC_LOAD) && !o_valid |=> !o_valid)
        else $error("result produced by a load");

    // reset empties the output
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule : fpfa_checker

bind fixed_partition_fit_allocator_unit fpfa_checker u_fpfa_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .i_data  (i_data),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_data  (o_data)
);
`default_nettype wire
